@@ rtl/dtt_pkg.sv @@
// Shared types, constants and helpers for the deadline timer table.
package dtt_pkg;

   localparam int SLOT_ID_W  = 4;
   localparam int PERIOD_W   = 32;
   localparam int TIME_W     = 48;
   localparam int WINDOW_W   = 32;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 3;
   localparam int MAX_OUT    = 16;
   localparam int OUT_CNT_W  = 4;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 56;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd3600000;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_RESET   = 3'd2,
      OP_REFRESH = 3'd3,
      OP_TICK    = 3'd4,
      OP_QUERY   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_INACTIVE  = 3'd1,
      STS_UNCHANGED = 3'd2,
      STS_FULL      = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_SCAN,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_SLOT_WR,
      ST_TK_HIT,
      ST_TK_MIN,
      ST_TK_FIX,
      ST_TK_WR,
      ST_QRY_SCAN,
      ST_QRY_DONE,
      ST_EMIT
   } state_type;

   // base + inc, clamped at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] base,
                                                 logic [PERIOD_W-1:0] inc);
      logic [TIME_W:0] s;
      s = {1'b0, base} + {{(TIME_W+1-PERIOD_W){1'b0}}, inc};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

@@ rtl/deadline_timer_table.sv @@
// Deadline timer table: slot store, sequencer and shared time adder.
//
//  channel | dir | handshake               | contents
//  --------+-----+-------------------------+------------------------------------------
//  req     | in  | req_tvalid / req_tready | tuser operation, tdata slot/period/flags/now
//  rsp     | out | rsp_tvalid / rsp_tready | tuser status, tdata slot/wait, tlast
//  csr     | in  | csr_valid / csr_ready   | rollover window, always ready
//
// One request at a time; req_tready is high only while the sequencer is idle.
// Cancel, reset and refresh address their slot directly. Add scans up from slot 0
// to the lowest free slot. Query scans all slots once. Tick makes an expiry pass,
// then one ordered min-search pass over the deadline memory per reported slot.
// Each slot visit reads the deadline memory once; that port sets the pace.
// Reset is synchronous; slot valid bits clear at once, no clearing pass.
// A stalled rsp channel holds the sequencer in its emit step until the transfer.
module deadline_timer_table #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: slot_id[3:0], period_ms[35:4], is_recurring[36],
   //            restart_now[37], now_ms[85:38], zero pad[87:86]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dtt_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [dtt_pkg::OP_W-1:0]            req_tuser,   // operation
   // rsp_tdata: result_slot[3:0], wait_ms[51:4], zero pad[55:52]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dtt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [dtt_pkg::STATUS_W-1:0]        rsp_tuser,   // status
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dtt_pkg::WINDOW_W-1:0]        csr_data
);

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);
   localparam int TW = dtt_pkg::TIME_W;
   localparam int PW = dtt_pkg::PERIOD_W;

   // sequencer
   dtt_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   // latched request
   logic [dtt_pkg::OP_W-1:0]      op_ff;
   logic [dtt_pkg::SLOT_ID_W-1:0] slot_ff;
   logic [PW-1:0]                 period_ff;
   logic                          rec_ff, restart_ff;
   logic [TW-1:0]                 now_ff;

   logic [dtt_pkg::WINDOW_W-1:0]  window_ff;
   logic [TW-1:0]                 prev_tick_ff, prev_tick_in;

   // per-slot flags
   logic [TIMER_SLOTS-1:0] active_ff, active_in, recur_ff, recur_in;
   logic [TIMER_SLOTS-1:0] hit_ff, hit_in, done_ff, done_in;

   // scan pipeline: issue address, then compare on registered read data
   logic [SLOT_W-1:0] idx_ff, idx_in, cmp_idx_ff, cmp_idx_in;
   logic              iss_ff, iss_in, cmp_vld_ff, cmp_vld_in;
   logic              scanning, scan_end;

   // running minimum
   logic              best_vld_ff, best_vld_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0]     best_dl_ff, best_dl_in;

   logic              all_ff, all_in;
   logic [dtt_pkg::OUT_CNT_W-1:0] k_ff, k_in;
   logic [TW-1:0]     start_ff, start_in;

   // pending result
   logic [dtt_pkg::SLOT_ID_W-1:0] pend_slot_ff, pend_slot_in;
   dtt_pkg::status_type           pend_status_ff, pend_status_in;
   logic                          pend_last_ff, pend_last_in;
   logic [TW-1:0]                 pend_wait_ff, pend_wait_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dtt_pkg::SLOT_ID_W-1:0] rsp_slot_ff;
   dtt_pkg::status_type           rsp_status_ff;
   logic                          rsp_last_ff;
   logic [TW-1:0]                 rsp_wait_ff;
   logic                          rsp_free, emit_fire;

   // period / deadline memories
   logic [PW-1:0]     per_mem [TIMER_SLOTS];
   logic [TW-1:0]     dl_mem  [TIMER_SLOTS];
   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic [PW-1:0]     rd_per_ff, per_wdata;
   logic [TW-1:0]     rd_dl_ff, dl_wdata;
   logic              per_we, dl_we;

   // shared saturating time adder
   logic [TW-1:0] au_base, au_sum;
   logic [PW-1:0] au_inc;

   logic              req_accept;
   logic              slot_ok;
   logic [SLOT_W-1:0] slot_sel;
   logic              rollover;
   logic              cand;

   assign req_tready = (state_ff == dtt_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign slot_sel = SLOT_W'(slot_ff);
   assign slot_ok  = (32'(slot_ff) < TIMER_SLOTS) && active_ff[slot_sel];

   // backward jump beyond the window expires everything
   assign rollover = (now_ff < prev_tick_ff) &&
                     ((prev_tick_ff - now_ff) > {{(TW-dtt_pkg::WINDOW_W){1'b0}}, window_ff});

   assign scanning = (state_ff == dtt_pkg::ST_TK_HIT) || (state_ff == dtt_pkg::ST_TK_MIN) ||
                     (state_ff == dtt_pkg::ST_QRY_SCAN);
   assign scan_end = cmp_vld_ff && (cmp_idx_ff == LAST_SLOT);

   assign rd_addr = scanning ? idx_ff :
                    ((state_ff == dtt_pkg::ST_TK_FIX) || (state_ff == dtt_pkg::ST_TK_WR)) ?
                    best_idx_ff : slot_sel;

   assign au_base = (state_ff == dtt_pkg::ST_SLOT_WR) ? start_ff : now_ff;
   assign au_inc  = ((state_ff == dtt_pkg::ST_ADD_SCAN) ||
                     ((state_ff == dtt_pkg::ST_SLOT_WR) && (op_ff == dtt_pkg::OP_RESET))) ?
                    period_ff : rd_per_ff;
   assign au_sum  = dtt_pkg::sat_add(au_base, au_inc);

   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = (state_ff == dtt_pkg::ST_EMIT) && rsp_free;

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         dtt_pkg::ST_IDLE: begin
            if (req_accept) state_in = dtt_pkg::ST_DECODE;
         end
         dtt_pkg::ST_DECODE: begin
            ret_in = dtt_pkg::ST_IDLE;
            case (op_ff)
               dtt_pkg::OP_ADD:    state_in = dtt_pkg::ST_ADD_SCAN;
               dtt_pkg::OP_CANCEL: state_in = dtt_pkg::ST_EMIT;
               dtt_pkg::OP_RESET,
               dtt_pkg::OP_REFRESH: state_in = slot_ok ? dtt_pkg::ST_SLOT_RD : dtt_pkg::ST_EMIT;
               dtt_pkg::OP_TICK:   state_in = (|active_ff) ? dtt_pkg::ST_TK_HIT : dtt_pkg::ST_EMIT;
               dtt_pkg::OP_QUERY:  state_in = dtt_pkg::ST_QRY_SCAN;
               default:            state_in = dtt_pkg::ST_IDLE;
            endcase
         end
         dtt_pkg::ST_ADD_SCAN: begin
            if (!active_ff[idx_ff] || (idx_ff == LAST_SLOT)) state_in = dtt_pkg::ST_EMIT;
         end
         dtt_pkg::ST_SLOT_RD: state_in = dtt_pkg::ST_SLOT_CHK;
         dtt_pkg::ST_SLOT_CHK: begin
            if ((op_ff == dtt_pkg::OP_RESET) && (period_ff == rd_per_ff) && !restart_ff)
               state_in = dtt_pkg::ST_EMIT;
            else
               state_in = dtt_pkg::ST_SLOT_WR;
         end
         dtt_pkg::ST_SLOT_WR: state_in = dtt_pkg::ST_EMIT;
         dtt_pkg::ST_TK_HIT: begin
            if (scan_end) state_in = (hit_in == '0) ? dtt_pkg::ST_EMIT : dtt_pkg::ST_TK_MIN;
         end
         dtt_pkg::ST_TK_MIN: begin
            if (scan_end) begin
               state_in = dtt_pkg::ST_EMIT;
               ret_in   = dtt_pkg::ST_TK_FIX;
            end
         end
         dtt_pkg::ST_TK_FIX: begin
            if (recur_ff[best_idx_ff]) state_in = dtt_pkg::ST_TK_WR;
            else state_in = pend_last_ff ? dtt_pkg::ST_IDLE : dtt_pkg::ST_TK_MIN;
         end
         dtt_pkg::ST_TK_WR: state_in = pend_last_ff ? dtt_pkg::ST_IDLE : dtt_pkg::ST_TK_MIN;
         dtt_pkg::ST_QRY_SCAN: begin
            if (scan_end) state_in = dtt_pkg::ST_QRY_DONE;
         end
         dtt_pkg::ST_QRY_DONE: state_in = dtt_pkg::ST_EMIT;
         dtt_pkg::ST_EMIT: begin
            if (rsp_free) state_in = ret_ff;
         end
         default: state_in = dtt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      active_in      = active_ff;
      recur_in       = recur_ff;
      hit_in         = hit_ff;
      done_in        = done_ff;
      idx_in         = idx_ff;
      iss_in         = iss_ff;
      cmp_vld_in     = scanning && iss_ff;
      cmp_idx_in     = idx_ff;
      best_vld_in    = best_vld_ff;
      best_idx_in    = best_idx_ff;
      best_dl_in     = best_dl_ff;
      all_in         = all_ff;
      k_in           = k_ff;
      start_in       = start_ff;
      prev_tick_in   = prev_tick_ff;
      pend_slot_in   = pend_slot_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      pend_wait_in   = pend_wait_ff;
      per_we         = 1'b0;
      dl_we          = 1'b0;
      wr_addr        = slot_sel;
      per_wdata      = period_ff;
      dl_wdata       = au_sum;
      cand           = 1'b0;

      // scan address issue
      if (scanning && iss_ff) begin
         if (idx_ff == LAST_SLOT) iss_in = 1'b0;
         else idx_in = idx_ff + SLOT_W'(1);
      end

      case (state_ff)
         dtt_pkg::ST_DECODE: begin
            pend_slot_in   = '0;
            pend_status_in = dtt_pkg::STS_OK;
            pend_last_in   = 1'b1;
            pend_wait_in   = '0;
            idx_in         = '0;
            iss_in         = 1'b0;
            best_vld_in    = 1'b0;
            case (op_ff)
               dtt_pkg::OP_CANCEL: begin
                  if (slot_ok) active_in[slot_sel] = 1'b0;
                  else pend_status_in = dtt_pkg::STS_INACTIVE;
               end
               dtt_pkg::OP_RESET,
               dtt_pkg::OP_REFRESH: begin
                  if (!slot_ok) pend_status_in = dtt_pkg::STS_INACTIVE;
               end
               dtt_pkg::OP_TICK: begin
                  if (|active_ff) begin
                     all_in       = rollover;
                     prev_tick_in = now_ff;
                     hit_in       = '0;
                     done_in      = '0;
                     k_in         = '0;
                     iss_in       = 1'b1;
                  end else begin
                     pend_status_in = dtt_pkg::STS_EMPTY;
                  end
               end
               dtt_pkg::OP_QUERY: iss_in = 1'b1;
               default: ;
            endcase
         end
         dtt_pkg::ST_ADD_SCAN: begin
            if (!active_ff[idx_ff]) begin
               active_in[idx_ff] = 1'b1;
               recur_in[idx_ff]  = rec_ff;
               per_we            = 1'b1;
               dl_we             = 1'b1;
               wr_addr           = idx_ff;
               pend_slot_in      = dtt_pkg::SLOT_ID_W'(idx_ff);
            end else if (idx_ff == LAST_SLOT) begin
               pend_status_in = dtt_pkg::STS_FULL;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         dtt_pkg::ST_SLOT_CHK: begin
            if ((op_ff == dtt_pkg::OP_RESET) && (period_ff == rd_per_ff) && !restart_ff)
               pend_status_in = dtt_pkg::STS_UNCHANGED;
            // start of the current period, or now on a refresh or a restart
            if ((op_ff == dtt_pkg::OP_REFRESH) || restart_ff)
               start_in = now_ff;
            else if (rd_dl_ff >= {{(TW-PW){1'b0}}, rd_per_ff})
               start_in = rd_dl_ff - {{(TW-PW){1'b0}}, rd_per_ff};
            else
               start_in = '0;
         end
         dtt_pkg::ST_SLOT_WR: begin
            dl_we  = 1'b1;
            per_we = (op_ff == dtt_pkg::OP_RESET);
         end
         dtt_pkg::ST_TK_HIT: begin
            if (cmp_vld_ff)
               hit_in[cmp_idx_ff] = active_ff[cmp_idx_ff] && (all_ff || (rd_dl_ff <= now_ff));
            if (scan_end) begin
               idx_in      = '0;
               iss_in      = 1'b1;
               best_vld_in = 1'b0;
               if (hit_in == '0) pend_status_in = dtt_pkg::STS_EMPTY;
            end
         end
         dtt_pkg::ST_TK_MIN: begin
            // strict compare in ascending order: ties go to the lower slot
            cand = cmp_vld_ff && hit_ff[cmp_idx_ff] && !done_ff[cmp_idx_ff] &&
                   (!best_vld_ff || (rd_dl_ff < best_dl_ff));
            if (cand) begin
               best_vld_in = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_dl_in  = rd_dl_ff;
            end
            if (scan_end) begin
               done_in[best_idx_in] = 1'b1;
               pend_slot_in   = dtt_pkg::SLOT_ID_W'(best_idx_in);
               pend_status_in = dtt_pkg::STS_OK;
               pend_last_in   = (k_ff == dtt_pkg::OUT_CNT_W'(dtt_pkg::MAX_OUT - 1)) ||
                                ((hit_ff & ~done_in) == '0);
               pend_wait_in   = '0;
               k_in           = k_ff + dtt_pkg::OUT_CNT_W'(1);
            end
         end
         dtt_pkg::ST_TK_FIX: begin
            if (!recur_ff[best_idx_ff]) begin
               active_in[best_idx_ff] = 1'b0;
               idx_in      = '0;
               iss_in      = !pend_last_ff;
               best_vld_in = 1'b0;
            end
         end
         dtt_pkg::ST_TK_WR: begin
            // recurring: rearm at now + period
            dl_we       = 1'b1;
            wr_addr     = best_idx_ff;
            idx_in      = '0;
            iss_in      = !pend_last_ff;
            best_vld_in = 1'b0;
         end
         dtt_pkg::ST_QRY_SCAN: begin
            cand = cmp_vld_ff && active_ff[cmp_idx_ff] &&
                   (!best_vld_ff || (rd_dl_ff < best_dl_ff));
            if (cand) begin
               best_vld_in = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_dl_in  = rd_dl_ff;
            end
         end
         dtt_pkg::ST_QRY_DONE: begin
            if (!best_vld_ff) begin
               pend_status_in = dtt_pkg::STS_EMPTY;
               pend_wait_in   = {TW{1'b1}};
            end else if (best_dl_ff > now_ff) begin
               pend_wait_in = best_dl_ff - now_ff;
            end else begin
               pend_wait_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtt_pkg::ST_IDLE;
         active_ff    <= '0;
         recur_ff     <= '0;
         window_ff    <= dtt_pkg::WINDOW_RESET;
         prev_tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         recur_ff     <= recur_in;
         prev_tick_ff <= prev_tick_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         cmp_vld_ff   <= cmp_vld_in;
         if (csr_valid && csr_ready) window_ff <= csr_data;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ret_ff         <= ret_in;
      hit_ff         <= hit_in;
      done_ff        <= done_in;
      idx_ff         <= idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_vld_ff    <= best_vld_in;
      best_idx_ff    <= best_idx_in;
      best_dl_ff     <= best_dl_in;
      all_ff         <= all_in;
      k_ff           <= k_in;
      start_ff       <= start_in;
      pend_slot_ff   <= pend_slot_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      pend_wait_ff   <= pend_wait_in;
      if (req_accept) begin
         op_ff      <= req_tuser;
         slot_ff    <= req_tdata[3:0];
         period_ff  <= req_tdata[35:4];
         rec_ff     <= req_tdata[36];
         restart_ff <= req_tdata[37];
         now_ff     <= req_tdata[85:38];
      end
      if (emit_fire) begin
         rsp_slot_ff   <= pend_slot_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_last_ff   <= pend_last_ff;
         rsp_wait_ff   <= pend_wait_ff;
      end
   end

   // slot memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (per_we) per_mem[wr_addr] <= per_wdata;
      if (dl_we)  dl_mem[wr_addr]  <= dl_wdata;
      rd_per_ff <= per_mem[rd_addr];
      rd_dl_ff  <= dl_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dtt_pkg::RSP_DATA_W - TW - dtt_pkg::SLOT_ID_W){1'b0}},
                        rsp_wait_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
